[src/tsot_pkg.sv]
// Shared types, constants and register indexes for the trigger shape overlap test.
package tsot_pkg;

  // Coordinate width; Q(CB-16).16 signed.
  localparam int CB        = 32;
  localparam int DATA_W    = (CB > 32) ? 64 : 32;
  localparam int ADDR_LSB  = (CB > 32) ? 3 : 2;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = ADDR_LSB + REG_IDX_W;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [CB:0]   coord_ext_t;
  typedef logic [CB-2:0]        radius_t;
  typedef logic [CB-1:0]        mag_t;
  typedef logic [2*CB-1:0]      square_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Register indexes of the configuration port.
  localparam reg_idx_t REG_VOL_IS_CIRCLE = 3'd0;
  localparam reg_idx_t REG_VOL_MIN_X     = 3'd1;
  localparam reg_idx_t REG_VOL_MAX_X     = 3'd2;
  localparam reg_idx_t REG_VOL_MIN_Y     = 3'd3;
  localparam reg_idx_t REG_VOL_MAX_Y     = 3'd4;
  localparam reg_idx_t REG_VOL_CENTER_X  = 3'd5;
  localparam reg_idx_t REG_VOL_CENTER_Y  = 3'd6;
  localparam reg_idx_t REG_VOL_RADIUS    = 3'd7;

  // One shape: bounding box, circle center and radius.
  typedef struct packed {
    logic    is_circle;
    coord_t  min_x;
    coord_t  max_x;
    coord_t  min_y;
    coord_t  max_y;
    coord_t  cx;
    coord_t  cy;
    radius_t radius;
  } shape_t;

  // Result of the compare stage: distances and radius ready for squaring.
  typedef struct packed {
    logic reject;
    logic use_sq;
    logic box_hit;
    mag_t mag_x;
    mag_t mag_y;
    mag_t rad;
  } prep_t;

  // Result of the squaring stage.
  typedef struct packed {
    logic    reject;
    logic    use_sq;
    logic    box_hit;
    square_t sq_x;
    square_t sq_y;
    square_t sq_r;
  } sq_stage_t;

  // Sign-extend a coordinate by one bit.
  function automatic coord_ext_t sx(input coord_t c);
    sx = {c[CB-1], c};
  endfunction

endpackage

[src/tsot_in_if.sv]
// Probe input channel: valid/ready handshake with the probe shape as payload.
interface tsot_in_if;
  import tsot_pkg::*;

  logic    valid;
  logic    ready;
  logic    probe_is_circle;
  coord_t  probe_min_x;
  coord_t  probe_max_x;
  coord_t  probe_min_y;
  coord_t  probe_max_y;
  coord_t  probe_cx;
  coord_t  probe_cy;
  radius_t probe_radius;

  modport source (
    output valid, probe_is_circle, probe_min_x, probe_max_x, probe_min_y,
           probe_max_y, probe_cx, probe_cy, probe_radius,
    input  ready
  );

  modport sink (
    input  valid, probe_is_circle, probe_min_x, probe_max_x, probe_min_y,
           probe_max_y, probe_cx, probe_cy, probe_radius,
    output ready
  );
endinterface

[src/tsot_out_if.sv]
// Result channel: valid/ready handshake carrying the overlap flag.
interface tsot_out_if;
  logic valid;
  logic ready;
  logic overlaps;

  modport source (output valid, overlaps, input ready);
  modport sink   (input valid, overlaps, output ready);
endinterface

[src/tsot_cfg.sv]
// APB-style register bank that holds the trigger volume.
module tsot_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tsot_pkg::PADDR_W-1:0] paddr,
  input  logic [tsot_pkg::DATA_W-1:0]  pwdata,
  output logic [tsot_pkg::DATA_W-1:0]  prdata,
  output tsot_pkg::shape_t             vol
);
  import tsot_pkg::*;

  shape_t   vol_r;
  shape_t   vol_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = paddr[ADDR_LSB +: REG_IDX_W];
  assign wr_en = psel && penable && pwrite;
  assign vol   = vol_r;

  // Write decode.
  always_comb begin
    vol_nxt = vol_r;
    if (wr_en) begin
      case (idx)
        REG_VOL_IS_CIRCLE: vol_nxt.is_circle = pwdata[0];
        REG_VOL_MIN_X:     vol_nxt.min_x     = pwdata[CB-1:0];
        REG_VOL_MAX_X:     vol_nxt.max_x     = pwdata[CB-1:0];
        REG_VOL_MIN_Y:     vol_nxt.min_y     = pwdata[CB-1:0];
        REG_VOL_MAX_Y:     vol_nxt.max_y     = pwdata[CB-1:0];
        REG_VOL_CENTER_X:  vol_nxt.cx        = pwdata[CB-1:0];
        REG_VOL_CENTER_Y:  vol_nxt.cy        = pwdata[CB-1:0];
        REG_VOL_RADIUS:    vol_nxt.radius    = pwdata[CB-2:0];
        default:           vol_nxt = vol_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r <= '0;
    end else begin
      vol_r <= vol_nxt;
    end
  end

  // Read mux returns the raw register bits, zero-extended.
  always_comb begin
    case (idx)
      REG_VOL_IS_CIRCLE: prdata = DATA_W'(vol_r.is_circle);
      REG_VOL_MIN_X:     prdata = DATA_W'($unsigned(vol_r.min_x));
      REG_VOL_MAX_X:     prdata = DATA_W'($unsigned(vol_r.max_x));
      REG_VOL_MIN_Y:     prdata = DATA_W'($unsigned(vol_r.min_y));
      REG_VOL_MAX_Y:     prdata = DATA_W'($unsigned(vol_r.max_y));
      REG_VOL_CENTER_X:  prdata = DATA_W'($unsigned(vol_r.cx));
      REG_VOL_CENTER_Y:  prdata = DATA_W'($unsigned(vol_r.cy));
      REG_VOL_RADIUS:    prdata = DATA_W'(vol_r.radius);
      default:           prdata = '0;
    endcase
  end

endmodule

[src/tsot_prep.sv]
// Compare stage: bounding-box reject, box-box test and clamped distances.
module tsot_prep (
  input  logic             clk,
  input  logic             en,
  input  tsot_pkg::shape_t probe,
  input  tsot_pkg::shape_t vol,
  output tsot_pkg::prep_t  prep_r
);
  import tsot_pkg::*;

  // Distance from c to the interval [lo, hi]; below lo takes lo first.
  function automatic mag_t clamp_mag(input coord_t c, input coord_t lo, input coord_t hi);
    coord_ext_t d_lo;
    coord_ext_t d_hi;
    d_lo = sx(lo) - sx(c);
    d_hi = sx(c) - sx(hi);
    if (c < lo) begin
      clamp_mag = d_lo[CB-1:0];
    end else if (c > hi) begin
      clamp_mag = d_hi[CB-1:0];
    end else begin
      clamp_mag = '0;
    end
  endfunction

  prep_t      prep_nxt;
  coord_ext_t vr_e;
  coord_ext_t vb_min_x, vb_max_x, vb_min_y, vb_max_y;
  logic       vcirc, pcirc, both_circ;
  coord_t     c_x, c_y, lo_x, hi_x, lo_y, hi_y;

  assign vcirc     = vol.is_circle;
  assign pcirc     = probe.is_circle;
  assign both_circ = vcirc && pcirc;
  assign vr_e      = coord_ext_t'({2'b00, vol.radius});

  // Volume bounds: the box itself, or center plus or minus radius.
  always_comb begin
    if (vcirc) begin
      vb_min_x = sx(vol.cx) - vr_e;
      vb_max_x = sx(vol.cx) + vr_e;
      vb_min_y = sx(vol.cy) - vr_e;
      vb_max_y = sx(vol.cy) + vr_e;
    end else begin
      vb_min_x = sx(vol.min_x);
      vb_max_x = sx(vol.max_x);
      vb_min_y = sx(vol.min_y);
      vb_max_y = sx(vol.max_y);
    end
  end

  // Pick the circle and the box for the closest-point test. For two circles
  // the box shrinks to the probe center, which yields the center distance.
  always_comb begin
    if (both_circ) begin
      c_x  = vol.cx;     c_y  = vol.cy;
      lo_x = probe.cx;   hi_x = probe.cx;
      lo_y = probe.cy;   hi_y = probe.cy;
    end else if (vcirc) begin
      c_x  = vol.cx;      c_y  = vol.cy;
      lo_x = probe.min_x; hi_x = probe.max_x;
      lo_y = probe.min_y; hi_y = probe.max_y;
    end else begin
      c_x  = probe.cx;    c_y  = probe.cy;
      lo_x = vol.min_x;   hi_x = vol.max_x;
      lo_y = vol.min_y;   hi_y = vol.max_y;
    end
  end

  always_comb begin
    prep_nxt.reject = !(vb_min_x <= sx(probe.max_x) && sx(probe.min_x) <= vb_max_x &&
                        vb_min_y <= sx(probe.max_y) && sx(probe.min_y) <= vb_max_y);
    prep_nxt.use_sq  = vcirc || pcirc;
    prep_nxt.box_hit = vol.min_x <= probe.max_x && probe.min_x <= vol.max_x &&
                       vol.min_y <= probe.max_y && probe.min_y <= vol.max_y;
    prep_nxt.mag_x   = clamp_mag(c_x, lo_x, hi_x);
    prep_nxt.mag_y   = clamp_mag(c_y, lo_y, hi_y);
    // Radius of the exact test: the sum of both radii for two circles.
    if (both_circ) begin
      prep_nxt.rad = {1'b0, vol.radius} + {1'b0, probe.radius};
    end else if (vcirc) begin
      prep_nxt.rad = {1'b0, vol.radius};
    end else begin
      prep_nxt.rad = {1'b0, probe.radius};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

[src/tsot_square.sv]
// Squaring stage: three parallel multipliers for dx*dx, dy*dy and r*r.
module tsot_square (
  input  logic                clk,
  input  logic                en,
  input  tsot_pkg::prep_t     prep,
  output tsot_pkg::sq_stage_t sq_r
);
  import tsot_pkg::*;

  sq_stage_t sq_nxt;

  always_comb begin
    sq_nxt.reject  = prep.reject;
    sq_nxt.use_sq  = prep.use_sq;
    sq_nxt.box_hit = prep.box_hit;
    sq_nxt.sq_x    = square_t'(prep.mag_x) * square_t'(prep.mag_x);
    sq_nxt.sq_y    = square_t'(prep.mag_y) * square_t'(prep.mag_y);
    sq_nxt.sq_r    = square_t'(prep.rad) * square_t'(prep.rad);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

[src/tsot_decide.sv]
// Decision stage: distance-squared compare and the result register.
module tsot_decide (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  tsot_pkg::sq_stage_t sq,
  output logic                overlaps_r
);
  import tsot_pkg::*;

  logic [2*CB:0] dist_sq;
  logic          circ_hit;
  logic          overlaps_nxt;

  assign dist_sq      = {1'b0, sq.sq_x} + {1'b0, sq.sq_y};
  assign circ_hit     = dist_sq <= {1'b0, sq.sq_r};
  assign overlaps_nxt = !sq.reject && (sq.use_sq ? circ_hit : sq.box_hit);

  always_ff @(posedge clk) begin
    if (en) begin
      overlaps_r <= overlaps_nxt;
    end
  end

`ifndef SYNTHESIS
  // A bounding-box reject must never come out as an overlap.
  a_reject_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    en && sq.reject |=> !overlaps_r)
    else $error("rejected probe reported as overlapping");
`endif

endmodule

[src/trigger_shape_overlap_test.sv]
// Top level of the trigger shape overlap test: volume registers and a four-stage pipeline.
//
//  Channel  Direction  Transfer                 Payload
//  in_ch    sink       valid & ready            probe shape (box or circle)
//  out_ch   source     valid & ready            overlaps flag
//  cfg_*    slave      psel & penable & pwrite  trigger volume registers
//
// One probe is accepted every cycle unless a stalled out_ch has filled the pipeline. An
// accepted probe passes the input, compare, multiply and decision registers in that
// order, and out_ch.valid rises when the decision (result) register loads.
// The 32x32 squaring multipliers sit in a stage of their own. Reset clears
// the volume registers and all stage valid bits.
// A stalled result register holds its transaction; earlier stages keep
// moving until they reach a full stage, so bubbles are filled during a stall.
module trigger_shape_overlap_test (
  input  logic                         clk,
  input  logic                         rst_n,
  tsot_in_if.sink                      in_ch,
  tsot_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tsot_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [tsot_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [tsot_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import tsot_pkg::*;

  shape_t    vol;
  shape_t    probe_r;
  prep_t     prep_r;
  sq_stage_t sq_r;
  logic      overlaps_r;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  assign cfg_pready = 1'b1;

  tsot_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .vol     (vol)
  );

  // A stage can take new data when it is empty or its content moves on.
  assign s4_rdy = !s4_vld_r || out_ch.ready;
  assign s3_rdy = !s3_vld_r || s4_rdy;
  assign s2_rdy = !s2_vld_r || s3_rdy;
  assign s1_rdy = !s1_vld_r || s2_rdy;

  assign in_ch.ready = s1_rdy;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_ch.valid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
      if (s3_rdy) s3_vld_r <= s2_vld_r;
      if (s4_rdy) s4_vld_r <= s3_vld_r;
    end
  end

  // Input register for the probe transaction.
  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_rdy) begin
      probe_r.is_circle <= in_ch.probe_is_circle;
      probe_r.min_x     <= in_ch.probe_min_x;
      probe_r.max_x     <= in_ch.probe_max_x;
      probe_r.min_y     <= in_ch.probe_min_y;
      probe_r.max_y     <= in_ch.probe_max_y;
      probe_r.cx        <= in_ch.probe_cx;
      probe_r.cy        <= in_ch.probe_cy;
      probe_r.radius    <= in_ch.probe_radius;
    end
  end

  tsot_prep u_prep (
    .clk    (clk),
    .en     (s1_vld_r && s2_rdy),
    .probe  (probe_r),
    .vol    (vol),
    .prep_r (prep_r)
  );

  tsot_square u_square (
    .clk  (clk),
    .en   (s2_vld_r && s3_rdy),
    .prep (prep_r),
    .sq_r (sq_r)
  );

  tsot_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (s3_vld_r && s4_rdy),
    .sq         (sq_r),
    .overlaps_r (overlaps_r)
  );

  assign out_ch.valid    = s4_vld_r;
  assign out_ch.overlaps = overlaps_r;

`ifndef SYNTHESIS
  // A result can only appear if the squaring stage held a transaction.
  a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s4_vld_r) |-> $past(s3_vld_r))
    else $error("result appeared without a transaction in the squaring stage");

  // With an empty result register the pipeline always takes input.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !s4_vld_r |-> in_ch.ready)
    else $error("input stalled although the result register is empty");

  // A full pipeline under output stall must refuse input.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted into a full stalled pipeline");

  // Every accepted transaction occupies the input stage on the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_vld_r)
    else $error("accepted transaction lost at the input stage");
`endif

endmodule
